// ===== rtl/core/htsed_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the HTML tag stripper / entity decoder.
// No dependencies; imported by html_tag_strip_entity_decode.
package htsed_pkg;

  // Entity table geometry
  localparam int ENT_NUM    = 6;  // number of recognized entities
  localparam int ENT_MAX    = 6;  // longest entity text, '&' through ';'
  localparam int PEND_DEPTH = 5;  // bytes of an entity prefix held at most
  localparam int RES_MAX    = 6;  // result words one input word can cause
  localparam int OBUF_DEPTH = 7;  // result buffer: one waiting word plus a full burst

  localparam logic [7:0] CH_LT  = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT  = 8'h3E;  // '>'
  localparam logic [7:0] CH_AMP = 8'h26;  // '&'

  // &lt; &gt; &amp; &quot; &apos; &nbsp; (zero padded)
  localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAX] = '{
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
    '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
  };

  localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6};

  localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h20};

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       out_last;
  } out_word_t;

endpackage

// ===== rtl/core/html_tag_strip_entity_decode.sv =====
`timescale 1ns / 1ps
// HTML tag stripper with entity decoder, top level.
// Depends on htsed_pkg for word types and the entity table.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data) takes one byte of marked-up
//   text per word; in_data.in_last flags the final byte of a text.
//   Output channel (out_valid / out_ready / out_data) gives one plain-text
//   word per handshake; out_data.out_valid is 0 only on the end-marker word
//   sent when the final byte produced nothing, and out_data.out_last marks
//   the final word of each text.
//   Bytes from '<' through '>' are dropped. The six entities &lt; &gt; &amp;
//   &quot; &apos; &nbsp; are decoded; a broken entity comes out verbatim.
// Timing:
//   A result word is registered when its input word is accepted. Plain
//   text streams at one byte per cycle while the output takes every word.
//   A byte that yields n words (entity flush, stream end) holds the input
//   until the result buffer, which drains at one word per cycle while
//   out_ready is high, is back to at most one word.
//   in_ready depends only on buffer fill (at most one word left), so one
//   word may sit stalled at the output while the next input is taken.
// Reset: rst (sync, active high) empties the result buffer and clears the
//   tag flag and the entity prefix count. No clearing pass is needed.
module html_tag_strip_entity_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  htsed_pkg::in_word_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output htsed_pkg::out_word_t out_data
);
  import htsed_pkg::*;

  // Parse state
  logic       inside_tag;
  logic       inside_tag_next;
  logic [2:0] pending_count;
  logic [2:0] pending_count_next;
  logic [7:0] pending_bytes [PEND_DEPTH];

  // Result buffer: word 0 drives the output, shifts down on each pop
  out_word_t  obuf [OBUF_DEPTH];
  out_word_t  obuf_next [OBUF_DEPTH];
  logic [2:0] ocnt;
  logic [2:0] ocnt_next;

  logic take;
  logic pop;
  logic base;

  // Per-byte decode results
  logic [7:0]  c;
  logic        last;
  logic [2:0]  pcv;
  logic [2:0]  cand_len;
  logic        any_full;
  logic        any_pre;
  logic [7:0]  dec;
  logic [2:0]  keep;      // held prefix bytes flushed this word
  logic        emit_b;    // one more byte follows the flushed prefix
  logic [7:0]  b;
  logic        wr_en;
  logic [2:0]  wr_idx;
  logic [2:0]  nres;
  logic [2:0]  nres_eff;
  logic [7:0]  ext [RES_MAX];
  out_word_t   res [OBUF_DEPTH];

  assign c    = in_data.in_char;
  assign last = in_data.in_last;

  assign out_valid = (ocnt != 3'd0);
  assign out_data  = obuf[0];
  assign in_ready  = (ocnt <= 3'd1);
  assign take      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;
  // Word 0 still waiting: new burst lands behind it
  assign base      = (ocnt == 3'd1) & ~pop;

  // Entity match against held prefix plus the incoming byte
  always_comb begin
    logic agree;
    pcv      = (pending_count > 3'(PEND_DEPTH)) ? 3'd0 : pending_count;
    cand_len = 3'(pcv + 3'd1);
    any_full = 1'b0;
    any_pre  = 1'b0;
    dec      = 8'h00;
    for (int e = ENT_NUM - 1; e >= 0; e--) begin
      agree = (c == ENT_TEXT[e][pcv]);
      for (int k = 0; k < PEND_DEPTH; k++) begin
        if (3'(k) < pcv && pending_bytes[k] != ENT_TEXT[e][k]) begin
          agree = 1'b0;
        end
      end
      if (agree && ENT_LEN[e] == cand_len) begin
        any_full = 1'b1;
        dec      = ENT_CHAR[e];
      end
      if (agree && ENT_LEN[e] > cand_len) begin
        any_pre = 1'b1;
      end
    end
  end

  // Output list is always: first keep held bytes, then optionally byte b
  always_comb begin
    logic plain;
    keep               = 3'd0;
    emit_b             = 1'b0;
    b                  = c;
    plain              = 1'b0;
    wr_en              = 1'b0;
    wr_idx             = pcv;
    inside_tag_next    = inside_tag;
    pending_count_next = pcv;

    if (pcv != 3'd0 && any_full) begin
      emit_b             = 1'b1;
      b                  = dec;
      pending_count_next = 3'd0;
    end else if (pcv != 3'd0 && any_pre && pcv < 3'(PEND_DEPTH)) begin
      if (last) begin
        // stream ends mid-entity: prefix and this byte go out verbatim
        keep   = pcv;
        emit_b = 1'b1;
      end else begin
        wr_en              = 1'b1;
        pending_count_next = cand_len;
      end
    end else begin
      keep               = pcv;
      pending_count_next = 3'd0;
      plain              = 1'b1;
    end

    if (plain) begin
      if (inside_tag) begin
        if (c == CH_GT) begin
          inside_tag_next = 1'b0;
        end
      end else if (c == CH_LT) begin
        inside_tag_next = 1'b1;
      end else if (c == CH_AMP) begin
        if (last) begin
          emit_b = 1'b1;
        end else begin
          wr_en              = 1'b1;
          wr_idx             = 3'd0;
          pending_count_next = 3'd1;
        end
      end else begin
        emit_b = 1'b1;
      end
    end

    if (last) begin
      inside_tag_next    = 1'b0;
      pending_count_next = 3'd0;
    end
  end

  // Build result words
  always_comb begin
    for (int k = 0; k < PEND_DEPTH; k++) begin
      ext[k] = pending_bytes[k];
    end
    ext[PEND_DEPTH] = b;

    nres     = 3'(keep + {2'b00, emit_b});
    nres_eff = nres;
    for (int i = 0; i < RES_MAX; i++) begin
      res[i].out_char  = (3'(i) < keep) ? ext[i] : b;
      res[i].out_valid = 1'b1;
      res[i].out_last  = last && (3'(i) == 3'(nres - 3'd1));
    end
    res[OBUF_DEPTH-1] = '0;

    if (last && nres == 3'd0) begin
      // end marker, no character
      res[0].out_char  = 8'h00;
      res[0].out_valid = 1'b0;
      res[0].out_last  = 1'b1;
      nres_eff         = 3'd1;
    end
  end

  // Result buffer next state
  always_comb begin
    for (int i = 0; i < OBUF_DEPTH; i++) begin
      obuf_next[i] = obuf[i];
    end
    ocnt_next = ocnt;
    if (take) begin
      obuf_next[0] = base ? obuf[0] : res[0];
      for (int i = 1; i < OBUF_DEPTH; i++) begin
        obuf_next[i] = base ? res[i-1] : res[i];
      end
      ocnt_next = 3'(nres_eff + {2'b00, base});
    end else if (pop) begin
      for (int i = 0; i < OBUF_DEPTH - 1; i++) begin
        obuf_next[i] = obuf[i+1];
      end
      ocnt_next = 3'(ocnt - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag    <= 1'b0;
      pending_count <= 3'd0;
      ocnt          <= 3'd0;
    end else begin
      ocnt <= ocnt_next;
      if (take) begin
        inside_tag    <= inside_tag_next;
        pending_count <= pending_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OBUF_DEPTH; i++) begin
      obuf[i] <= obuf_next[i];
    end
    if (take && wr_en) begin
      pending_bytes[wr_idx] <= c;
    end
  end

`ifndef NO_ASSERTIONS
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pending_count <= 3'(PEND_DEPTH))
    else $error("entity prefix count out of range");

  a_pend_no_tag: assert property (@(posedge clk) disable iff (rst)
    pending_count != 3'd0 |-> !inside_tag)
    else $error("entity prefix held inside a tag");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    take && last |=> pending_count == 3'd0 && !inside_tag)
    else $error("state not cleared after final byte");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.out_valid |-> out_data.out_last && out_data.out_char == 8'h00)
    else $error("malformed end marker");

  a_take_room: assert property (@(posedge clk) disable iff (rst)
    take && base |=> ocnt != 3'd0 && $stable(obuf[0]))
    else $error("waiting result word overwritten by new burst");
`endif

endmodule

// ===== tb/html_tag_strip_entity_decode_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for html_tag_strip_entity_decode: tag stripping and entity decoding.
// Depends on htsed_pkg (word types) and the html_tag_strip_entity_decode RTL.
module html_tag_strip_entity_decode_test;
  import htsed_pkg::*;

  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int RAND_ITEMS = 450;

  // Entity table kept locally: text padded with zeros, length, decoded byte
  localparam int ENTITIES = 6;
  localparam logic [7:0] ENTITY_TEXT [ENTITIES][6] = '{
    '{"&", "l", "t", ";", 8'h00, 8'h00},
    '{"&", "g", "t", ";", 8'h00, 8'h00},
    '{"&", "a", "m", "p", ";", 8'h00},
    '{"&", "q", "u", "o", "t", ";"},
    '{"&", "a", "p", "o", "s", ";"},
    '{"&", "n", "b", "s", "p", ";"}
  };
  localparam int ENTITY_LEN [ENTITIES] = '{4, 4, 5, 6, 6, 6};
  localparam logic [7:0] ENTITY_CHAR [ENTITIES] = '{"<", ">", "&", 8'h22, 8'h27, " "};
  localparam int HELD_MAX = 5;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  html_tag_strip_entity_decode dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Input words still to send; hold_q marks words that wait for a drained output
  in_word_t  stim_q[$];
  bit        hold_q[$];
  bit        hold_next = 1'b0;

  // Plain-text words predicted but not yet seen, and the burst of one input word
  out_word_t plain_q[$];
  out_word_t burst_q[$];

  // Shadow state of the stripper
  bit         tag_open = 1'b0;
  int         held_n = 0;
  logic [7:0] held [HELD_MAX];

  int bad = 0;
  int quiet = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_gap = 0;
  int out_calm = 0;

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------
  task automatic emit_char(input logic [7:0] c, input logic v);
    out_word_t w;
    w.out_char  = c;
    w.out_valid = v;
    w.out_last  = 1'b0;
    burst_q.insert(burst_q.size(), w);
  endtask

  // Release the held '&' prefix verbatim
  task automatic flush_held();
    for (int i = 0; i < held_n; i++) emit_char(held[i], 1'b1);
    held_n = 0;
  endtask

  // A byte seen with nothing held
  task automatic plain_byte(input logic [7:0] c);
    if (tag_open) begin
      if (c == ">") tag_open = 1'b0;
    end else if (c == "<") begin
      tag_open = 1'b1;
    end else if (c == "&") begin
      held[0] = c;
      held_n = 1;
    end else begin
      emit_char(c, 1'b1);
    end
  endtask

  task automatic predict_words(input in_word_t w);
    logic [7:0] cand [HELD_MAX + 1];
    int len;
    bit done;
    bit prefix;
    bit agree;
    if (held_n > HELD_MAX) held_n = 0;
    if (held_n > 0) begin
      for (int i = 0; i < held_n; i++) cand[i] = held[i];
      cand[held_n] = w.in_char;
      len = held_n + 1;
      done = 1'b0;
      prefix = 1'b0;
      for (int e = 0; e < ENTITIES; e++) begin
        if (ENTITY_LEN[e] >= len) begin
          agree = 1'b1;
          for (int i = 0; i < len; i++)
            if (cand[i] != ENTITY_TEXT[e][i]) agree = 1'b0;
          if (agree && ENTITY_LEN[e] == len && !done) begin
            emit_char(ENTITY_CHAR[e], 1'b1);
            done = 1'b1;
          end
          if (agree && ENTITY_LEN[e] > len) prefix = 1'b1;
        end
      end
      if (done) begin
        held_n = 0;
      end else if (prefix && len <= HELD_MAX) begin
        held[held_n] = w.in_char;
        held_n = len;
      end else begin
        // broken entity: prefix goes out as is, breaking byte handled fresh
        flush_held();
        plain_byte(w.in_char);
      end
    end else begin
      plain_byte(w.in_char);
    end
    if (w.in_last) begin
      flush_held();
      tag_open = 1'b0;
      if (burst_q.size() == 0) emit_char(8'h00, 1'b0);  // end marker only
      burst_q[burst_q.size() - 1].out_last = 1'b1;
    end
    foreach (burst_q[i]) plain_q.insert(plain_q.size(), burst_q[i]);
    burst_q.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Mostly zero gaps, some short, a few long; now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_byte(input logic [7:0] c, input bit last = 1'b0);
    in_word_t w;
    w.in_char = c;
    w.in_last = last;
    stim_q.insert(stim_q.size(), w);
    hold_q.insert(hold_q.size(), hold_next || ($urandom_range(0, 99) == 0));
    hold_next = 1'b0;
  endtask

  task automatic add_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], last && (i == s.len() - 1));
  endtask

  // One text: mostly plain bytes, whole entities and closed tags, with some
  // broken entities, stray markup and texts cut off mid-entity or mid-tag
  task automatic add_random_text();
    int n_tok;
    int kind;
    int e;
    int k;
    int plen;
    logic [7:0] c;
    n_tok = $urandom_range(1, 10);
    for (int t = 0; t < n_tok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        if ($urandom_range(0, 4) == 0) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == "<" || c == "&") c = ".";
        end
        add_byte(c);
      end else if (kind < 60) begin
        e = $urandom_range(0, ENTITIES - 1);
        for (int i = 0; i < ENTITY_LEN[e]; i++) add_byte(ENTITY_TEXT[e][i]);
      end else if (kind < 75) begin
        e = $urandom_range(0, ENTITIES - 1);
        plen = $urandom_range(1, ENTITY_LEN[e] - 1);
        for (int i = 0; i < plen; i++) add_byte(ENTITY_TEXT[e][i]);
        if (t != n_tok - 1 || $urandom_range(0, 3) != 0) add_byte(8'($urandom_range(0, 255)));
      end else if (kind < 92) begin
        add_byte("<");
        k = $urandom_range(0, 5);
        for (int i = 0; i < k; i++) begin
          c = 8'($urandom_range(0, 255));
          if (c == ">") c = "a";
          add_byte(c);
        end
        if (t != n_tok - 1 || $urandom_range(0, 5) != 0) add_byte(">");
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            add_byte(">");
          end
          1: begin
            add_byte("&");
          end
          default: begin
            add_byte("<");
          end
        endcase
      end
    end
    stim_q[stim_q.size() - 1].in_last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next word after its gap, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    bit       nv;
    in_word_t nd;
    bit       hold;
    nd = '0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_words(in_data);
      // only pick a new word once the current one is gone
      if (!(in_valid && !in_ready)) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (stim_q.size() > 0) begin
          hold = hold_q[0] && (plain_q.size() != 0);
          if (!hold) begin
            nd = stim_q.pop_front();
            void'(hold_q.pop_front());
            nv = 1'b1;
            in_gap = pick_gap(in_calm);
          end
        end
        in_valid <= nv;
        if (nv) in_data <= nd;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, compares each accepted word in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (plain_q.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("unexpected word: char %02h valid %0b last %0b",
                     out_data.out_char, out_data.out_valid, out_data.out_last);
        end else begin
          want = plain_q.pop_front();
          if (out_data.out_char != want.out_char || out_data.out_valid != want.out_valid ||
              out_data.out_last != want.out_last) begin
            bad++;
            if (bad <= 10)
              $display("mismatch: want char %02h valid %0b last %0b, %s %02h %0b %0b",
                       want.out_char, want.out_valid, want.out_last, "got",
                       out_data.out_char, out_data.out_valid, out_data.out_last);
          end
        end
        out_gap = pick_gap(out_calm);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : run
    int first_rand;
    // Directed: byte extremes, a tag, entities, a new '&' breaking a prefix,
    // a tag breaking a prefix, text ending mid-entity, and text ending in a
    // tag so only the end marker comes out
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("<a>", 1'b0);
    add_text("&lt;", 1'b0);
    add_text("&&gt;", 1'b0);
    add_text("&am<", 1'b0);
    add_text(">", 1'b0);
    add_text("&nb", 1'b1);
    add_text("<p", 1'b1);

    // Random texts; the first one waits until the directed words are all out
    first_rand = stim_q.size();
    hold_next = 1'b1;
    while (stim_q.size() < first_rand + RAND_ITEMS) add_random_text();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (plain_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (bad == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/htsed_pkg.sv
rtl/core/html_tag_strip_entity_decode.sv
tb/html_tag_strip_entity_decode_test.sv
